// ===== rtl/oadc_pkg.sv =====
// Shared types, constants and helper functions of the obstacle avoiding drive controller.
package oadc_pkg;

  localparam int LOG_DEPTH_DEF = 256;

  localparam int NOW_W   = 32;
  localparam int DIST_W  = 14;
  localparam int DIR_W   = 4;
  localparam int BRUSH_W = 2;
  localparam int MB_W    = 3;
  localparam int THR_W   = 10;
  localparam int HOLD_W  = 16;
  localparam int DUTY_W  = 11;
  localparam int STATE_W = 3;
  localparam int MODE_W  = 2;
  localparam int CODE_W  = 2;

  localparam int IN_BITS    = NOW_W + 4 * DIST_W + DIR_W + BRUSH_W + MB_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DANGER      = 3'd0,
    CFG_WARNING     = 3'd1,
    CFG_REAR_CLEAR  = 3'd2,
    CFG_TURN_HOLD   = 3'd3,
    CFG_REVERSE_HOLD = 3'd4,
    CFG_STOP_HOLD   = 3'd5
  } cfg_idx_t;

  localparam logic [THR_W-1:0]  DANGER_RST       = 10'd25;
  localparam logic [THR_W-1:0]  WARNING_RST      = 10'd45;
  localparam logic [THR_W-1:0]  REAR_CLEAR_RST   = 10'd20;
  localparam logic [HOLD_W-1:0] TURN_HOLD_RST    = 16'd600;
  localparam logic [HOLD_W-1:0] REVERSE_HOLD_RST = 16'd500;
  localparam logic [HOLD_W-1:0] STOP_HOLD_RST    = 16'd150;

  localparam logic signed [DUTY_W-1:0] DUTY_FWD  = 11'sd600;
  localparam logic signed [DUTY_W-1:0] DUTY_SLOW = 11'sd300;
  localparam logic signed [DUTY_W-1:0] DUTY_TURN = 11'sd700;
  localparam logic signed [DUTY_W-1:0] DUTY_BACK = 11'sd450;

  typedef enum logic [STATE_W-1:0] {
    ST_STOP  = 3'd0,
    ST_FWD   = 3'd1,
    ST_SLOW  = 3'd2,
    ST_LEFT  = 3'd3,
    ST_RIGHT = 3'd4,
    ST_BACK  = 3'd5
  } drv_state_t;

  typedef enum logic [MODE_W-1:0] {
    MD_MANUAL = 2'd0,
    MD_AUTO   = 2'd1,
    MD_RETURN = 2'd2
  } mode_t;

  typedef enum logic [CODE_W-1:0] {
    MV_FWD   = 2'd0,
    MV_BACK  = 2'd1,
    MV_LEFT  = 2'd2,
    MV_RIGHT = 2'd3
  } move_t;

  typedef struct packed {
    logic [THR_W-1:0]  danger;
    logic [THR_W-1:0]  warning;
    logic [THR_W-1:0]  rear_clear;
    logic [HOLD_W-1:0] turn_hold;
    logic [HOLD_W-1:0] reverse_hold;
    logic [HOLD_W-1:0] stop_hold;
  } cfg_t;

  typedef struct packed {
    drv_state_t       cur;
    mode_t            mode;
    logic [NOW_W-1:0] entry;
    logic             spk;
    logic             brush;
    logic [MB_W-1:0]  last_mb;
  } ctrl_t;

  function automatic move_t code_of_state(drv_state_t s);
    move_t c;
    case (s)
      ST_FWD:  c = MV_FWD;
      ST_BACK: c = MV_BACK;
      ST_LEFT: c = MV_LEFT;
      default: c = MV_RIGHT;
    endcase
    return c;
  endfunction

  function automatic drv_state_t inverse_of_code(move_t c);
    drv_state_t s;
    case (c)
      MV_FWD:  s = ST_BACK;
      MV_BACK: s = ST_FWD;
      MV_LEFT: s = ST_RIGHT;
      default: s = ST_LEFT;
    endcase
    return s;
  endfunction

  function automatic logic signed [DUTY_W-1:0] duty_left(drv_state_t s);
    logic signed [DUTY_W-1:0] d;
    case (s)
      ST_FWD:   d = DUTY_FWD;
      ST_SLOW:  d = DUTY_SLOW;
      ST_LEFT:  d = -DUTY_TURN;
      ST_RIGHT: d = DUTY_TURN;
      ST_BACK:  d = -DUTY_BACK;
      default:  d = '0;
    endcase
    return d;
  endfunction

  function automatic logic signed [DUTY_W-1:0] duty_right(drv_state_t s);
    logic signed [DUTY_W-1:0] d;
    case (s)
      ST_FWD:   d = DUTY_FWD;
      ST_SLOW:  d = DUTY_SLOW;
      ST_LEFT:  d = DUTY_TURN;
      ST_RIGHT: d = -DUTY_TURN;
      ST_BACK:  d = -DUTY_BACK;
      default:  d = '0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/oadc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module oadc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/oadc_cfg_regs.sv =====
// Configuration register file: thresholds and minimum hold times.
module oadc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [oadc_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [oadc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output oadc_pkg::cfg_t                     cfg
);

  oadc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.danger       <= oadc_pkg::DANGER_RST;
      cfg_r.warning      <= oadc_pkg::WARNING_RST;
      cfg_r.rear_clear   <= oadc_pkg::REAR_CLEAR_RST;
      cfg_r.turn_hold    <= oadc_pkg::TURN_HOLD_RST;
      cfg_r.reverse_hold <= oadc_pkg::REVERSE_HOLD_RST;
      cfg_r.stop_hold    <= oadc_pkg::STOP_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        oadc_pkg::CFG_DANGER:       cfg_r.danger       <= cfg_wdata[oadc_pkg::THR_W-1:0];
        oadc_pkg::CFG_WARNING:      cfg_r.warning      <= cfg_wdata[oadc_pkg::THR_W-1:0];
        oadc_pkg::CFG_REAR_CLEAR:   cfg_r.rear_clear   <= cfg_wdata[oadc_pkg::THR_W-1:0];
        oadc_pkg::CFG_TURN_HOLD:    cfg_r.turn_hold    <= cfg_wdata[oadc_pkg::HOLD_W-1:0];
        oadc_pkg::CFG_REVERSE_HOLD: cfg_r.reverse_hold <= cfg_wdata[oadc_pkg::HOLD_W-1:0];
        oadc_pkg::CFG_STOP_HOLD:    cfg_r.stop_hold    <= cfg_wdata[oadc_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/oadc_step.sv =====
// Next-state logic for one control tick: mode buttons, drive decision, log push and pop.
module oadc_step #(
  parameter int LOG_DEPTH = oadc_pkg::LOG_DEPTH_DEF,
  localparam int CNT_W = $clog2(LOG_DEPTH + 1),
  localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1
) (
  input  oadc_pkg::cfg_t                            cfg,
  input  oadc_pkg::ctrl_t                           ctrl,
  input  logic [CNT_W-1:0]                          cnt,
  input  oadc_pkg::move_t                           top_code,
  input  logic [oadc_pkg::NOW_W-1:0]                now_ms,
  input  logic [oadc_pkg::DIST_W-1:0]               front_cm,
  input  logic [oadc_pkg::DIST_W-1:0]               rear_cm,
  input  logic [oadc_pkg::DIST_W-1:0]               left_cm,
  input  logic [oadc_pkg::DIST_W-1:0]               right_cm,
  input  logic [oadc_pkg::DIR_W-1:0]                direction_buttons,
  input  logic [oadc_pkg::BRUSH_W-1:0]              brush_buttons,
  input  logic [oadc_pkg::MB_W-1:0]                 mode_buttons,
  output oadc_pkg::ctrl_t                           ctrl_nxt,
  output logic [CNT_W-1:0]                          cnt_nxt,
  output logic                                      log_we,
  output logic [AW-1:0]                             log_addr,
  output oadc_pkg::move_t                           log_code,
  output logic                                      buzzer_on,
  output logic signed [oadc_pkg::DUTY_W-1:0]        left_duty,
  output logic signed [oadc_pkg::DUTY_W-1:0]        right_duty
);

  function automatic oadc_pkg::ctrl_t enter_st(oadc_pkg::ctrl_t c, oadc_pkg::drv_state_t nx,
                                               logic [oadc_pkg::NOW_W-1:0] t);
    oadc_pkg::ctrl_t r;
    r = c;
    if (nx != c.cur) begin
      r.cur   = nx;
      r.entry = t;
    end
    return r;
  endfunction

  logic [oadc_pkg::MB_W-1:0]  rise;
  logic [oadc_pkg::NOW_W-1:0] elapsed;
  logic                       hold_ok;
  logic                       df, dl, dr;
  logic                       go;
  oadc_pkg::drv_state_t       tgt;
  oadc_pkg::ctrl_t            v;
  logic [CNT_W-1:0]           c;

  assign df = front_cm < oadc_pkg::DIST_W'(cfg.danger);
  assign dl = left_cm  < oadc_pkg::DIST_W'(cfg.danger);
  assign dr = right_cm < oadc_pkg::DIST_W'(cfg.danger);

  always_comb begin
    rise     = mode_buttons & ~ctrl.last_mb;
    v        = ctrl;
    c        = cnt;
    go       = 1'b0;
    tgt      = oadc_pkg::ST_STOP;
    log_we   = 1'b0;
    log_addr = cnt[AW-1:0];
    log_code = oadc_pkg::MV_FWD;

    if (rise[0]) begin
      if (v.mode == oadc_pkg::MD_AUTO) begin
        v.mode = oadc_pkg::MD_MANUAL;
        v      = enter_st(v, oadc_pkg::ST_STOP, now_ms);
      end else begin
        v.mode = oadc_pkg::MD_AUTO;
        c      = '0;
      end
    end
    if (rise[1] && (c != '0)) begin
      v.mode = oadc_pkg::MD_RETURN;
      v      = enter_st(v, oadc_pkg::ST_STOP, now_ms);
    end
    if (rise[2]) begin
      v.spk = ~v.spk;
    end
    v.last_mb = mode_buttons;

    elapsed = now_ms - v.entry;
    case (v.cur)
      oadc_pkg::ST_LEFT,
      oadc_pkg::ST_RIGHT: hold_ok = elapsed >= oadc_pkg::NOW_W'(cfg.turn_hold);
      oadc_pkg::ST_BACK:  hold_ok = elapsed >= oadc_pkg::NOW_W'(cfg.reverse_hold);
      oadc_pkg::ST_STOP:  hold_ok = elapsed >= oadc_pkg::NOW_W'(cfg.stop_hold);
      default:            hold_ok = 1'b1;
    endcase

    case (v.mode)
      oadc_pkg::MD_AUTO: begin
        if (hold_ok) begin
          go = 1'b1;
          if (df || dl || dr) begin
            if ((v.cur == oadc_pkg::ST_FWD) || (v.cur == oadc_pkg::ST_SLOW)) begin
              tgt = oadc_pkg::ST_STOP;
            end else if (df || (dl && dr)) begin
              if ((left_cm > right_cm) && !dl) begin
                tgt = oadc_pkg::ST_LEFT;
              end else if ((right_cm > left_cm) && !dr) begin
                tgt = oadc_pkg::ST_RIGHT;
              end else if (rear_cm > oadc_pkg::DIST_W'(cfg.rear_clear)) begin
                tgt = oadc_pkg::ST_BACK;
              end else begin
                tgt = oadc_pkg::ST_STOP;
              end
            end else if (dl) begin
              tgt = oadc_pkg::ST_RIGHT;
            end else begin
              tgt = oadc_pkg::ST_LEFT;
            end
          end else if (front_cm < oadc_pkg::DIST_W'(cfg.warning)) begin
            tgt = oadc_pkg::ST_SLOW;
          end else begin
            tgt = oadc_pkg::ST_FWD;
          end
        end
      end
      oadc_pkg::MD_RETURN: begin
        if (hold_ok) begin
          if (c == '0) begin
            v      = enter_st(v, oadc_pkg::ST_STOP, now_ms);
            v.mode = oadc_pkg::MD_MANUAL;
          end else begin
            c   = c - CNT_W'(1);
            go  = 1'b1;
            tgt = oadc_pkg::inverse_of_code(top_code);
          end
        end
      end
      default: begin
        go = 1'b1;
        if (direction_buttons[0]) begin
          tgt = oadc_pkg::ST_FWD;
        end else if (direction_buttons[1]) begin
          tgt = oadc_pkg::ST_BACK;
        end else if (direction_buttons[2]) begin
          tgt = oadc_pkg::ST_LEFT;
        end else if (direction_buttons[3]) begin
          tgt = oadc_pkg::ST_RIGHT;
        end else begin
          tgt = oadc_pkg::ST_STOP;
        end
        if (brush_buttons[0]) begin
          v.brush = 1'b1;
        end
        if (brush_buttons[1]) begin
          v.brush = 1'b0;
        end
      end
    endcase

    if (go) begin
      if ((tgt != v.cur) && (v.mode == oadc_pkg::MD_AUTO) && (c < CNT_W'(LOG_DEPTH)) &&
          (tgt != oadc_pkg::ST_STOP) && (tgt != oadc_pkg::ST_SLOW)) begin
        log_we   = 1'b1;
        log_addr = c[AW-1:0];
        log_code = oadc_pkg::code_of_state(tgt);
        c        = c + CNT_W'(1);
      end
      v = enter_st(v, tgt, now_ms);
    end

    ctrl_nxt = v;
    cnt_nxt  = c;
  end

  assign buzzer_on = ctrl_nxt.spk &&
                     (df || dl || dr || (rear_cm < oadc_pkg::DIST_W'(cfg.danger)));
  assign left_duty  = oadc_pkg::duty_left(ctrl_nxt.cur);
  assign right_duty = oadc_pkg::duty_right(ctrl_nxt.cur);

endmodule

// ===== rtl/obstacle_avoid_drive_controller.sv =====
// Top level of the obstacle avoiding drive controller: input register, state, move log, result register.
//
// Each input transaction is one control tick and yields exactly one result transaction. The block
// takes a new tick in every cycle while the result register is not stalled by out_tready: a tick
// is captured in the input register, the next-state logic runs on it in a single pass, and its
// result is loaded into the output register when that register is free or drained, which raises
// out_tvalid. The move log is a LOG_DEPTH x 2 RAM with a registered read; its top entry is read
// ahead after every tick (with a bypass of the entry just written), so a pop in return mode never
// waits. The log needs no clearing pass after reset. Configuration writes take effect at once and
// belong only to idle periods.
module obstacle_avoid_drive_controller #(
  parameter int LOG_DEPTH = oadc_pkg::LOG_DEPTH_DEF,
  localparam int CNT_W = $clog2(LOG_DEPTH + 1),
  localparam int OUT_BITS = oadc_pkg::STATE_W + 2 * oadc_pkg::DUTY_W + oadc_pkg::MODE_W + 2 + CNT_W,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // now_ms, front_cm, rear_cm, left_cm, right_cm, direction_buttons, brush_buttons, mode_buttons
  input  logic [oadc_pkg::IN_TDATA_W-1:0]       in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // drive_state, left_duty, right_duty, mode_now, brush_running, buzzer_on, logged_moves
  output logic [OUT_TDATA_W-1:0]                out_tdata,
  input  logic                                  cfg_we,
  input  logic [oadc_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  logic [oadc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

  localparam int FRONT_LSB = oadc_pkg::NOW_W;
  localparam int REAR_LSB  = FRONT_LSB + oadc_pkg::DIST_W;
  localparam int LEFT_LSB  = REAR_LSB + oadc_pkg::DIST_W;
  localparam int RIGHT_LSB = LEFT_LSB + oadc_pkg::DIST_W;
  localparam int DIR_LSB   = RIGHT_LSB + oadc_pkg::DIST_W;
  localparam int BRUSH_LSB = DIR_LSB + oadc_pkg::DIR_W;
  localparam int MB_LSB    = BRUSH_LSB + oadc_pkg::BRUSH_W;

  oadc_pkg::cfg_t                     cfg;
  logic                               in_vld_r;
  logic [oadc_pkg::IN_TDATA_W-1:0]    in_data_r;
  logic                               out_vld_r;
  logic [OUT_TDATA_W-1:0]             out_data_r;
  oadc_pkg::ctrl_t                    ctrl_r;
  logic [CNT_W-1:0]                   cnt_r;
  logic                               byp_r;
  oadc_pkg::move_t                    byp_code_r;

  logic                               adv;
  oadc_pkg::ctrl_t                    step_ctrl;
  logic [CNT_W-1:0]                   step_cnt;
  logic                               step_we;
  logic [AW-1:0]                      step_addr;
  oadc_pkg::move_t                    step_code;
  logic                               step_buzzer;
  logic signed [oadc_pkg::DUTY_W-1:0] step_ld;
  logic signed [oadc_pkg::DUTY_W-1:0] step_rd;

  logic                               log_we;
  logic [CNT_W-1:0]                   cnt_nxt;
  logic [AW-1:0]                      raddr;
  logic [oadc_pkg::CODE_W-1:0]        ram_q;
  oadc_pkg::move_t                    top_code;
  logic                               byp_nxt;
  logic [OUT_TDATA_W-1:0]             out_data_nxt;

  oadc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  oadc_step #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_step (
    .cfg               (cfg),
    .ctrl              (ctrl_r),
    .cnt               (cnt_r),
    .top_code          (top_code),
    .now_ms            (in_data_r[oadc_pkg::NOW_W-1:0]),
    .front_cm          (in_data_r[FRONT_LSB +: oadc_pkg::DIST_W]),
    .rear_cm           (in_data_r[REAR_LSB +: oadc_pkg::DIST_W]),
    .left_cm           (in_data_r[LEFT_LSB +: oadc_pkg::DIST_W]),
    .right_cm          (in_data_r[RIGHT_LSB +: oadc_pkg::DIST_W]),
    .direction_buttons (in_data_r[DIR_LSB +: oadc_pkg::DIR_W]),
    .brush_buttons     (in_data_r[BRUSH_LSB +: oadc_pkg::BRUSH_W]),
    .mode_buttons      (in_data_r[MB_LSB +: oadc_pkg::MB_W]),
    .ctrl_nxt          (step_ctrl),
    .cnt_nxt           (step_cnt),
    .log_we            (step_we),
    .log_addr          (step_addr),
    .log_code          (step_code),
    .buzzer_on         (step_buzzer),
    .left_duty         (step_ld),
    .right_duty        (step_rd)
  );

  // The read port always fetches the entry below the count that the next tick will see.
  assign log_we   = adv && step_we;
  assign cnt_nxt  = adv ? step_cnt : cnt_r;
  assign raddr    = AW'(cnt_nxt - CNT_W'(1));
  assign byp_nxt  = log_we && (step_addr == raddr);
  assign top_code = byp_r ? byp_code_r : oadc_pkg::move_t'(ram_q);

  oadc_ram #(
    .WIDTH (oadc_pkg::CODE_W),
    .DEPTH (LOG_DEPTH)
  ) u_log (
    .clk   (clk),
    .we    (log_we),
    .waddr (step_addr),
    .wdata (step_code),
    .raddr (raddr),
    .rdata (ram_q)
  );

  assign out_data_nxt = OUT_TDATA_W'({step_cnt, step_buzzer, step_ctrl.brush, step_ctrl.mode,
                                      step_rd, step_ld, step_ctrl.cur});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      ctrl_r    <= '{cur: oadc_pkg::ST_STOP, mode: oadc_pkg::MD_MANUAL, entry: '0,
                     spk: 1'b0, brush: 1'b0, last_mb: '0};
      cnt_r     <= '0;
      byp_r     <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
        ctrl_r    <= step_ctrl;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      cnt_r <= cnt_nxt;
      byp_r <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
    byp_code_r <= step_code;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(LOG_DEPTH))
    else $error("move count exceeds log depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    log_we |-> (step_cnt != '0) && (step_cnt <= CNT_W'(LOG_DEPTH)))
    else $error("log push with full log");

  a_push_auto: assert property (@(posedge clk) disable iff (!rst_n)
    log_we |-> (step_ctrl.mode == oadc_pkg::MD_AUTO) &&
               (step_cnt == CNT_W'(step_addr) + CNT_W'(1)))
    else $error("log push outside auto mode or without count increment");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r && (cnt_r == out_data_r[OUT_BITS-1 -: CNT_W]))
    else $error("processed tick did not produce a matching result");

endmodule
